// ----- rtl/ids_pkg.sv -----
// Shared constants, types and conversion functions for the indexed deque store.
`timescale 1ns / 1ps
`default_nettype none

package ids_pkg;

	localparam int CAPACITY   = 32;
	localparam int DATA_WIDTH = 32;

	localparam int KIND_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 6;
	localparam int STATUS_W = 2;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (OCC_W > POS_W) ? OCC_W : POS_W;

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [OCC_W-1:0]      occ_t;
	typedef logic [CMP_W-1:0]      cmp_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_HEAD_ADD  = 3'd0,
		KIND_TAIL_ADD  = 3'd1,
		KIND_HEAD_DROP = 3'd2,
		KIND_TAIL_DROP = 3'd3,
		KIND_INSERT    = 3'd4,
		KIND_ERASE     = 3'd5,
		KIND_DUMP_FWD  = 3'd6,
		KIND_DUMP_REV  = 3'd7
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE    = 2'd0,
		STATUS_IGNORED = 2'd1,
		STATUS_FULL    = 2'd2
	} status_t;

	// What every cell of the chain does.
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_ROT_FWD,
		CELL_ROT_REV
	} cell_op_t;

	// Command broadcast to all cells.
	typedef struct packed {
		cell_op_t op;
		idx_t     pos;
		idx_t     last_idx;
		data_t    value;
		data_t    head;
		data_t    tail;
	} cell_ctl_t;

	// Keep the low DATA_WIDTH bits of the sign-extended input value.
	function automatic data_t to_store(input logic [VALUE_W-1:0] v);
		logic [63:0] t;
		t = {{32{v[VALUE_W-1]}}, v};
		return t[DATA_WIDTH-1:0];
	endfunction

	// Sign-extend a stored entry and keep the low 32 bits.
	function automatic logic [VALUE_W-1:0] to_elem(input data_t d);
		logic [63:0] t;
		t = 64'(signed'(d));
		return t[VALUE_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ids_cell.sv -----
// One storage cell of the deque chain; it loads, shifts or rotates on command.
`timescale 1ns / 1ps
`default_nettype none

module ids_cell (
	input  wire logic              clk,
	input  wire ids_pkg::idx_t     idx,
	input  wire ids_pkg::cell_ctl_t ctl,
	input  wire ids_pkg::data_t    nbr_lo,
	input  wire ids_pkg::data_t    nbr_hi,
	output ids_pkg::data_t         data
);

	ids_pkg::data_t data_q;
	ids_pkg::data_t data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			ids_pkg::CELL_INSERT: begin
				if (idx == ctl.pos) begin
					data_d = ctl.value;
				end else if (idx > ctl.pos) begin
					data_d = nbr_lo;
				end
			end
			ids_pkg::CELL_REMOVE: begin
				if (idx >= ctl.pos) begin
					data_d = nbr_hi;
				end
			end
			ids_pkg::CELL_ROT_FWD: begin
				data_d = (idx == ctl.last_idx) ? ctl.head : nbr_hi;
			end
			ids_pkg::CELL_ROT_REV: begin
				data_d = (idx == '0) ? ctl.tail : nbr_lo;
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ----- rtl/indexed_deque_store.sv -----
// Top level of the indexed deque store: control, output register and the cell chain.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                   Contents
// s_axis   in         s_axis_tvalid/s_axis_tready tuser: kind; tdata: value, position
// m_axis   out        m_axis_tvalid/m_axis_tready tuser: status; tdata: element, count;
//                                                 tlast: final result of the transaction
//
// A mutation (push, pop, insert, erase) shifts the whole chain at once and writes one result
// to the output register, so mutations can follow every cycle unless the output stalls.
// A dump of N elements, once accepted, sends one element per cycle unless the output stalls,
// paced by the single head or tail read of the rotating chain; the chain is back in order
// once the last element leaves. Reset clears the occupancy; cell contents stay undefined
// until written. A stalled output holds its register, which stalls the dump and new input.

module indexed_deque_store (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // [31:0] value, [37:32] position, zero fill
	input  wire logic [2:0]  s_axis_tuser,  // [2:0] kind

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // [31:0] element, [37:32] count, zero fill
	output logic [1:0]       m_axis_tuser,  // [1:0] status
	output logic             m_axis_tlast
);

	localparam int CAP = ids_pkg::CAPACITY;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	state_t              state_q, state_d;
	ids_pkg::occ_t       occ_q, occ_d;
	ids_pkg::occ_t       rem_q, rem_d;
	logic                rev_q, rev_d;

	logic                out_valid_q;
	logic [ids_pkg::VALUE_W-1:0]  out_elem_q, out_elem_d;
	logic                out_last_q, out_last_d;
	ids_pkg::status_t    out_status_q, out_status_d;
	logic [ids_pkg::COUNT_W-1:0]  out_count_q;
	logic                load_out;

	logic                can_load;
	logic                in_fire;

	ids_pkg::kind_t                in_kind;
	logic [ids_pkg::VALUE_W-1:0]   in_value;
	logic [ids_pkg::POS_W-1:0]     in_pos;

	ids_pkg::cell_ctl_t  ctl;
	ids_pkg::data_t      cell_data [CAP];
	ids_pkg::idx_t       tail_idx;
	ids_pkg::data_t      tail_data;

	assign in_kind  = ids_pkg::kind_t'(s_axis_tuser);
	assign in_value = s_axis_tdata[31:0];
	assign in_pos   = s_axis_tdata[37:32];

	// The output register frees up when it is empty or being taken this cycle.
	assign can_load      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && can_load;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// The tail cell sits just below the occupancy.
	assign tail_idx  = ids_pkg::IDX_W'(occ_q - ids_pkg::OCC_W'(1));
	assign tail_data = cell_data[tail_idx];

	always_comb begin
		state_d      = state_q;
		occ_d        = occ_q;
		rem_d        = rem_q;
		rev_d        = rev_q;
		load_out     = 1'b0;
		out_elem_d   = '0;
		out_last_d   = 1'b1;
		out_status_d = ids_pkg::STATUS_DONE;

		ctl.op       = ids_pkg::CELL_HOLD;
		ctl.pos      = '0;
		ctl.last_idx = tail_idx;
		ctl.value    = ids_pkg::to_store(in_value);
		ctl.head     = cell_data[0];
		ctl.tail     = tail_data;

		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					load_out = 1'b1;
					unique case (in_kind) inside
						ids_pkg::KIND_HEAD_ADD, ids_pkg::KIND_TAIL_ADD: begin
							if (occ_q == ids_pkg::OCC_W'(CAP)) begin
								out_status_d = ids_pkg::STATUS_FULL;
							end else begin
								ctl.op  = ids_pkg::CELL_INSERT;
								ctl.pos = (in_kind == ids_pkg::KIND_HEAD_ADD) ?
									'0 : ids_pkg::IDX_W'(occ_q);
								occ_d   = occ_q + ids_pkg::OCC_W'(1);
							end
						end
						ids_pkg::KIND_HEAD_DROP, ids_pkg::KIND_TAIL_DROP: begin
							if (occ_q == '0) begin
								out_status_d = ids_pkg::STATUS_IGNORED;
							end else begin
								ctl.op  = ids_pkg::CELL_REMOVE;
								ctl.pos = (in_kind == ids_pkg::KIND_HEAD_DROP) ?
									'0 : ids_pkg::IDX_W'(occ_q - ids_pkg::OCC_W'(1));
								occ_d   = occ_q - ids_pkg::OCC_W'(1);
							end
						end
						ids_pkg::KIND_INSERT: begin
							// The index check wins over the full check.
							if (ids_pkg::cmp_t'(in_pos) > ids_pkg::cmp_t'(occ_q)) begin
								out_status_d = ids_pkg::STATUS_IGNORED;
							end else if (occ_q == ids_pkg::OCC_W'(CAP)) begin
								out_status_d = ids_pkg::STATUS_FULL;
							end else begin
								ctl.op  = ids_pkg::CELL_INSERT;
								ctl.pos = ids_pkg::IDX_W'(in_pos);
								occ_d   = occ_q + ids_pkg::OCC_W'(1);
							end
						end
						ids_pkg::KIND_ERASE: begin
							if (ids_pkg::cmp_t'(in_pos) >= ids_pkg::cmp_t'(occ_q)) begin
								out_status_d = ids_pkg::STATUS_IGNORED;
							end else begin
								ctl.op  = ids_pkg::CELL_REMOVE;
								ctl.pos = ids_pkg::IDX_W'(in_pos);
								occ_d   = occ_q - ids_pkg::OCC_W'(1);
							end
						end
						ids_pkg::KIND_DUMP_FWD, ids_pkg::KIND_DUMP_REV: begin
							if (occ_q == '0) begin
								// An empty dump reports a single ignored result.
								out_status_d = ids_pkg::STATUS_IGNORED;
							end else begin
								load_out = 1'b0;
								state_d  = ST_DUMP;
								rem_d    = occ_q;
								rev_d    = (in_kind == ids_pkg::KIND_DUMP_REV);
							end
						end
						default: begin
							out_status_d = ids_pkg::STATUS_IGNORED;
						end
					endcase
				end
			end
			ST_DUMP: begin
				if (can_load) begin
					// Emit the head (or tail) and rotate it to the other end.
					load_out   = 1'b1;
					out_elem_d = ids_pkg::to_elem(rev_q ? tail_data : cell_data[0]);
					out_last_d = (rem_q == ids_pkg::OCC_W'(1));
					ctl.op     = rev_q ? ids_pkg::CELL_ROT_REV : ids_pkg::CELL_ROT_FWD;
					rem_d      = rem_q - ids_pkg::OCC_W'(1);
					if (rem_q == ids_pkg::OCC_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			occ_q        <= '0;
			rem_q        <= '0;
			rev_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_elem_q   <= '0;
			out_last_q   <= 1'b0;
			out_status_q <= ids_pkg::STATUS_DONE;
			out_count_q  <= '0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			rem_q   <= rem_d;
			rev_q   <= rev_d;
			if (load_out) begin
				out_valid_q  <= 1'b1;
				out_elem_q   <= out_elem_d;
				out_last_q   <= out_last_d;
				out_status_q <= out_status_d;
				// The count field reports occupancy as it stands after the operation.
				out_count_q  <= ids_pkg::COUNT_W'(occ_d);
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_count_q, out_elem_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	// The chain of cells; each one sees its two neighbors.
	for (genvar g = 0; g < CAP; g++) begin : g_cell
		ids_pkg::data_t lo_w;
		ids_pkg::data_t hi_w;
		if (g == 0) begin : g_first
			assign lo_w = '0;
		end else begin : g_lo
			assign lo_w = cell_data[g-1];
		end
		if (g == CAP - 1) begin : g_last
			assign hi_w = '0;
		end else begin : g_hi
			assign hi_w = cell_data[g+1];
		end
		ids_cell u_cell (
			.clk    (clk),
			.idx    (ids_pkg::IDX_W'(g)),
			.ctl    (ctl),
			.nbr_lo (lo_w),
			.nbr_hi (hi_w),
			.data   (cell_data[g])
		);
	end

	// Occupancy never goes past the number of cells.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= ids_pkg::OCC_W'(CAP))
		else $error("occupancy above capacity");

	// While a dump runs, no input is taken and elements remain to be sent.
	a_dump_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |-> (!s_axis_tready && rem_q != '0))
		else $error("dump state inconsistent");

	// Occupancy only changes after an accepted input transaction.
	a_occ_change: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != $past(occ_q)) |-> $past(s_axis_tvalid && s_axis_tready))
		else $error("occupancy changed without input");

	// A dump leaves the occupancy untouched.
	a_dump_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |=> (occ_q == $past(occ_q)))
		else $error("occupancy changed during dump");

endmodule

`default_nettype wire

// ----- dv/tb_indexed_deque_store.sv -----
// Self-checking testbench for the indexed deque store against a queue model.
`timescale 1ns / 1ps

module tb_indexed_deque_store;

	typedef struct packed {
		ids_pkg::kind_t     kind;
		logic signed [31:0] value;
		logic [5:0]         position;
	} op_item_t;

	typedef struct packed {
		logic [31:0]      element;
		logic             last;
		logic [5:0]       count;
		ids_pkg::status_t status;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // [31:0] value, [37:32] position, zero fill
	logic [2:0]  s_axis_tuser = '0;   // [2:0] kind

	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // [31:0] element, [37:32] count, zero fill
	logic [1:0]  m_axis_tuser;        // [1:0] status
	logic        m_axis_tlast;

	// Operations waiting to be presented, and the one currently on the bus.
	op_item_t queued_ops[$];
	op_item_t presented_op;

	// Shadow copy of the stored sequence, head at index 0.
	ids_pkg::data_t shadow_deque[$];
	reply_t         awaited_replies[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int gen_occ = 0;     // occupancy as seen while generating stimulus
	bit growing = 1'b1;  // random stimulus trend: fill up or drain

	int mismatch_count = 0;
	int checked_count = 0;
	int ops_accepted = 0;
	int dumps_run = 0;
	int refused_full = 0;
	int ignored_ops = 0;

	indexed_deque_store i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Applies one accepted operation to the shadow sequence and queues the results it owes.
	function automatic void predict_replies(input op_item_t op);
		reply_t                                r;
		int                                    n;
		int                                    idx;
		logic signed [ids_pkg::DATA_WIDTH-1:0] stored;
		logic signed [31:0]                    widened;
		n = shadow_deque.size();
		stored = op.value;
		r.element = '0;
		r.last = 1'b1;
		r.count = '0;
		r.status = ids_pkg::STATUS_DONE;
		ops_accepted++;
		case (op.kind)
			ids_pkg::KIND_HEAD_ADD, ids_pkg::KIND_TAIL_ADD: begin
				if (n >= ids_pkg::CAPACITY)
					r.status = ids_pkg::STATUS_FULL;
				else if (op.kind == ids_pkg::KIND_HEAD_ADD)
					shadow_deque.insert(0, stored);
				else
					shadow_deque.insert(n, stored);
			end
			ids_pkg::KIND_HEAD_DROP, ids_pkg::KIND_TAIL_DROP: begin
				if (n == 0)
					r.status = ids_pkg::STATUS_IGNORED;
				else
					shadow_deque.delete(op.kind == ids_pkg::KIND_HEAD_DROP ? 0 : n - 1);
			end
			ids_pkg::KIND_INSERT: begin
				// The index check wins over the full check.
				if (op.position > n)
					r.status = ids_pkg::STATUS_IGNORED;
				else if (n >= ids_pkg::CAPACITY)
					r.status = ids_pkg::STATUS_FULL;
				else
					shadow_deque.insert(int'(op.position), stored);
			end
			ids_pkg::KIND_ERASE: begin
				if (op.position >= n)
					r.status = ids_pkg::STATUS_IGNORED;
				else
					shadow_deque.delete(int'(op.position));
			end
			default: begin
				dumps_run++;
				if (n == 0)
					r.status = ids_pkg::STATUS_IGNORED;
				for (int i = 0; i < n; i++) begin
					idx = (op.kind == ids_pkg::KIND_DUMP_FWD) ? i : n - 1 - i;
					stored = $signed(shadow_deque[idx]);
					widened = stored;
					r.element = widened;
					r.last = (i == n - 1);
					r.count = 6'(n);
					awaited_replies.insert(awaited_replies.size(), r);
				end
			end
		endcase
		if (r.status == ids_pkg::STATUS_FULL)
			refused_full++;
		if (r.status == ids_pkg::STATUS_IGNORED)
			ignored_ops++;
		// A non-empty dump has already queued its results above.
		if (!(op.kind inside {ids_pkg::KIND_DUMP_FWD, ids_pkg::KIND_DUMP_REV}) || n == 0) begin
			r.count = 6'(shadow_deque.size());
			awaited_replies.insert(awaited_replies.size(), r);
		end
	endfunction

	// Input side: a transaction completes when tvalid and tready were both high at this edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_replies(presented_op);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (queued_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					presented_op = queued_ops[0];
					queued_ops.delete(0);
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {2'b00, presented_op.position, presented_op.value};
					s_axis_tuser <= presented_op.kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side: random backpressure and an in-order check of every result transaction.
	always @(posedge clk) begin
		reply_t want;
		reply_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.element = m_axis_tdata[31:0];
				got.last = m_axis_tlast;
				got.count = m_axis_tdata[37:32];
				got.status = ids_pkg::status_t'(m_axis_tuser);
				checked_count++;
				if (awaited_replies.size() == 0) begin
					$display("%0t: expected no result, actual el=%0d last=%0b cnt=%0d st=%0d",
						$time, $signed(got.element), got.last, got.count, got.status);
					mismatch_count++;
				end else begin
					want = awaited_replies[0];
					awaited_replies.delete(0);
					if (got !== want) begin
						$display("%0t: expected el=%0d last=%0b cnt=%0d st=%0d", $time,
							$signed(want.element), want.last, want.count, want.status);
						$display("%0t:   actual el=%0d last=%0b cnt=%0d st=%0d", $time,
							$signed(got.element), got.last, got.count, got.status);
						mismatch_count++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Queues one operation and tracks the occupancy it will leave, so that random
	// positions can be aimed at valid indexes.
	task automatic queue_op(input ids_pkg::kind_t k, input logic [31:0] v, input logic [5:0] p);
		op_item_t op;
		op.kind = k;
		op.value = v;
		op.position = p;
		queued_ops.insert(queued_ops.size(), op);
		case (k)
			ids_pkg::KIND_HEAD_ADD, ids_pkg::KIND_TAIL_ADD:
				if (gen_occ < ids_pkg::CAPACITY) gen_occ++;
			ids_pkg::KIND_HEAD_DROP, ids_pkg::KIND_TAIL_DROP:
				if (gen_occ > 0) gen_occ--;
			ids_pkg::KIND_INSERT:
				if (p <= gen_occ && gen_occ < ids_pkg::CAPACITY) gen_occ++;
			ids_pkg::KIND_ERASE:
				if (p < gen_occ) gen_occ--;
			default: ;
		endcase
	endtask

	task automatic wait_ops_sent();
		while (queued_ops.size() != 0)
			@(posedge clk);
	endtask

	// One phase of random traffic at its own idle and stall rates. The stimulus swings between
	// filling the store to capacity and draining it, so full and empty corners recur.
	task automatic run_phase(input int idle_pct, input int stall_pct, input int n_ops);
		ids_pkg::kind_t k;
		logic [31:0]    v;
		logic [5:0]     p;
		int             roll;
		bit             grow_op;
		@(posedge clk);
		send_idle_pct <= idle_pct;
		recv_stall_pct <= stall_pct;
		repeat (n_ops) begin
			case ($urandom_range(7))
				0: v = 32'h8000_0000;
				1: v = 32'h7fff_ffff;
				2: v = 32'hffff_ffff;
				default: v = $urandom();
			endcase
			p = 6'($urandom_range(32));
			roll = $urandom_range(99);
			grow_op = growing ? (roll < 85) : (roll >= 85);
			if (roll >= 92) begin
				k = $urandom_range(1) ? ids_pkg::KIND_DUMP_FWD : ids_pkg::KIND_DUMP_REV;
			end else if (grow_op) begin
				case ($urandom_range(2))
					0: k = ids_pkg::KIND_HEAD_ADD;
					1: k = ids_pkg::KIND_TAIL_ADD;
					default: begin
						k = ids_pkg::KIND_INSERT;
						if ($urandom_range(9) != 0)
							p = 6'($urandom_range(gen_occ));
					end
				endcase
			end else begin
				case ($urandom_range(2))
					0: k = ids_pkg::KIND_HEAD_DROP;
					1: k = ids_pkg::KIND_TAIL_DROP;
					default: begin
						k = ids_pkg::KIND_ERASE;
						if (gen_occ != 0 && $urandom_range(9) != 0)
							p = 6'($urandom_range(gen_occ - 1));
					end
				endcase
			end
			queue_op(k, v, p);
			if (gen_occ == ids_pkg::CAPACITY && $urandom_range(3) == 0)
				growing = 1'b0;
			if (gen_occ == 0 && $urandom_range(2) == 0)
				growing = 1'b1;
		end
		wait_ops_sent();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, with no idling: empty-store corners first.
		queue_op(ids_pkg::KIND_HEAD_DROP, 32'd0, 6'd0);
		queue_op(ids_pkg::KIND_TAIL_DROP, 32'd0, 6'd0);
		queue_op(ids_pkg::KIND_ERASE, 32'd0, 6'd0);
		queue_op(ids_pkg::KIND_DUMP_FWD, 32'd0, 6'd0);
		queue_op(ids_pkg::KIND_DUMP_REV, 32'd0, 6'd0);
		queue_op(ids_pkg::KIND_INSERT, 32'h5555_aaaa, 6'd32);   // index past the end
		queue_op(ids_pkg::KIND_INSERT, 32'h7fff_ffff, 6'd0);    // insert into an empty store
		queue_op(ids_pkg::KIND_HEAD_ADD, 32'h8000_0000, 6'd63);
		queue_op(ids_pkg::KIND_TAIL_ADD, 32'hffff_ffff, 6'd0);
		queue_op(ids_pkg::KIND_TAIL_ADD, 32'h0000_0000, 6'd0);
		queue_op(ids_pkg::KIND_INSERT, 32'h1234_5678, 6'd2);    // middle of the sequence
		queue_op(ids_pkg::KIND_INSERT, 32'hcafe_f00d, 6'd5);    // at the end: adds at the tail
		queue_op(ids_pkg::KIND_INSERT, 32'h0000_0001, 6'd0);    // at the head: one head add
		queue_op(ids_pkg::KIND_DUMP_FWD, 32'hffff_ffff, 6'd63);
		queue_op(ids_pkg::KIND_DUMP_REV, 32'd0, 6'd0);
		queue_op(ids_pkg::KIND_ERASE, 32'd0, 6'd7);             // one past the last element
		queue_op(ids_pkg::KIND_ERASE, 32'd0, 6'd6);
		queue_op(ids_pkg::KIND_ERASE, 32'd0, 6'd0);
		queue_op(ids_pkg::KIND_ERASE, 32'd0, 6'd2);
		queue_op(ids_pkg::KIND_HEAD_DROP, 32'd0, 6'd0);
		queue_op(ids_pkg::KIND_TAIL_DROP, 32'd0, 6'd0);
		queue_op(ids_pkg::KIND_DUMP_FWD, 32'd0, 6'd0);
		wait_ops_sent();

		run_phase(0, 0, 35);
		run_phase(63, 0, 35);
		run_phase(0, 63, 35);
		run_phase(10, 10, 35);

		while (awaited_replies.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (awaited_replies.size() != 0) begin
			$display("%0t: expected %0d more results, actual none", $time,
				awaited_replies.size());
			mismatch_count++;
		end

		$display("Ran %0d operations, %0d of them dumps; %0d refused on full, %0d ignored.",
			ops_accepted, dumps_run, refused_full, ignored_ops);
		$display("Checked %0d result transactions, %0d mismatches.",
			checked_count, mismatch_count);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run under full backpressure.
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
